>>> sv/three_prime_rsa_crt_cipher_macros.svh
// Assertion helpers for the cipher block
`ifndef THREE_PRIME_RSA_CRT_CIPHER_MACROS_SVH
`define THREE_PRIME_RSA_CRT_CIPHER_MACROS_SVH
`define ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

>>> sv/tpr_pkg.sv
package tpr_pkg;
  localparam int WORD_W = 30;
  localparam int WIDE_W = 64;
  typedef enum logic [2:0] {
    REG_PUB = 3'd0,
    REG_PRIV = 3'd1,
    REG_P1 = 3'd2,
    REG_P2 = 3'd3,
    REG_P3 = 3'd4,
    REG_MOD = 3'd5
  } reg_idx_t;
  typedef struct packed {
    logic start;
    logic [WIDE_W-1:0] num;
    logic [WIDE_W-1:0] den;
  } div_req_t;
  typedef struct packed {
    logic done;
    logic [WIDE_W-1:0] quo;
    logic [WIDE_W-1:0] rem;
  } div_rsp_t;
endpackage

>>> sv/tpr_divider.sv
module tpr_divider (
  input  logic clk,
  input  logic rst,
  input  tpr_pkg::div_req_t req,
  output tpr_pkg::div_rsp_t rsp
);
  import tpr_pkg::*;
  logic busy;
  logic [6:0] cnt;
  logic [WIDE_W-1:0] quo, den;
  logic [WIDE_W:0] rem;
  logic [WIDE_W:0] trial;

  assign trial = {rem[WIDE_W-1:0], quo[WIDE_W-1]} - {1'b0, den};

  // restoring division, one quotient bit a cycle; divide by zero gives zeros
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
      cnt <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= (req.den != '0);
        rsp.done <= (req.den == '0);
        rsp.quo <= '0;
        rsp.rem <= '0;
        quo <= req.num;
        den <= req.den;
        rem <= '0;
        cnt <= 7'(WIDE_W);
      end else if (busy) begin
        if (!trial[WIDE_W]) begin
          rem <= trial;
          quo <= {quo[WIDE_W-2:0], 1'b1};
        end else begin
          rem <= {rem[WIDE_W-1:0], quo[WIDE_W-1]};
          quo <= {quo[WIDE_W-2:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
          rsp.quo <= !trial[WIDE_W] ? {quo[WIDE_W-2:0], 1'b1} : {quo[WIDE_W-2:0], 1'b0};
          rsp.rem <= !trial[WIDE_W] ? trial[WIDE_W-1:0] : {rem[WIDE_W-2:0], quo[WIDE_W-1]};
        end
      end
    end
  end
endmodule

>>> sv/three_prime_rsa_crt_cipher.sv
// Three-prime RSA cipher with CRT decryption.
// Drive mode and message with start high while busy is low; the item is
// taken at that edge and busy rises until the result is shown. The result
// appears on value with done high for one cycle; the receiver cannot stall.
// Configuration: write wr_en, wr_index, wr_data at any idle edge; index 0
// public exponent, 1 private exponent, 2..4 primes, 5 modulus. Other
// indexes are ignored.
// Every modular product and reduction goes through one shared 64-bit
// restoring divider; each request is awaited in S_WAIT. Encrypt: one
// base reduction, 30 squarings and one multiply per set exponent bit.
// Decrypt: three such exponentiations, three extended-Euclid inverses
// (one reduction plus one division per step, at most 15 divisions each),
// three term products and a final reduction. The divider sets the rate;
// a new item is taken only after done.
// Reset restores the register defaults (65537, 1, 2, 3, 5, 30) and idles.
module three_prime_rsa_crt_cipher #(
  parameter int PRIME_BITS = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic mode,
  input  logic [29:0] message,
  output logic done,
  output logic [29:0] value,
  input  logic wr_en,
  input  logic [2:0] wr_index,
  input  logic [29:0] wr_data
);
  import tpr_pkg::*;
  `include "three_prime_rsa_crt_cipher_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_RBASE, S_SQ, S_MUL, S_NEXT, S_INV_INIT, S_INV_DIV, S_INV_FIX,
    S_TERM, S_ACC, S_FINAL, S_OUT, S_WAIT
  } state_t;

  logic [29:0] pub_e, priv_e, modn;
  logic [9:0] p1, p2, p3;
  state_t state, ret;
  logic dmode;
  logic [29:0] msg;
  logic [29:0] m, e, base, acc;
  logic [4:0] bitn;
  logic [1:0] pidx;
  logic [9:0] res [3];
  logic [9:0] pm;
  logic [19:0] prod;
  logic signed [11:0] r0, r1, t0, t1;
  logic [63:0] sum;
  div_req_t dreq;
  div_rsp_t drsp;

  tpr_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign busy = (state != S_IDLE);

  always_comb begin
    pm = p1 & 10'((1 << PRIME_BITS) - 1);
    prod = 20'(p2 & 10'((1 << PRIME_BITS) - 1)) * 20'(p3 & 10'((1 << PRIME_BITS) - 1));
    case (pidx)
      2'd1: begin
        pm = p2 & 10'((1 << PRIME_BITS) - 1);
        prod = 20'(p1 & 10'((1 << PRIME_BITS) - 1)) * 20'(p3 & 10'((1 << PRIME_BITS) - 1));
      end
      2'd2: begin
        pm = p3 & 10'((1 << PRIME_BITS) - 1);
        prod = 20'(p1 & 10'((1 << PRIME_BITS) - 1)) * 20'(p2 & 10'((1 << PRIME_BITS) - 1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pub_e <= 30'd65537;
      priv_e <= 30'd1;
      p1 <= 10'd2;
      p2 <= 10'd3;
      p3 <= 10'd5;
      modn <= 30'd30;
      state <= S_IDLE;
      done <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      done <= 1'b0;
      dreq.start <= 1'b0;
      if (wr_en) begin
        case (wr_index)
          REG_PUB: pub_e <= wr_data;
          REG_PRIV: priv_e <= wr_data;
          REG_P1: p1 <= wr_data[9:0];
          REG_P2: p2 <= wr_data[9:0];
          REG_P3: p3 <= wr_data[9:0];
          REG_MOD: modn <= wr_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (start) begin
          dmode <= mode;
          msg <= message;
          pidx <= 2'd0;
          sum <= '0;
          if (mode) begin
            m <= 30'(p1 & 10'((1 << PRIME_BITS) - 1));
            e <= priv_e;
          end else begin
            m <= modn;
            e <= pub_e;
          end
          state <= S_RBASE;
        end
        S_RBASE: begin
          // reduce base; 1 mod m
          dreq.start <= 1'b1;
          dreq.num <= 64'(msg);
          dreq.den <= 64'(m);
          acc <= (m == 30'd1 || m == 30'd0) ? 30'd0 : 30'd1;
          bitn <= 5'd29;
          ret <= S_SQ;
          state <= S_WAIT;
        end
        S_WAIT: if (drsp.done) begin
          state <= ret;
          if (ret == S_SQ) base <= drsp.rem[29:0];
          if (ret == S_MUL || ret == S_NEXT) acc <= drsp.rem[29:0];
          if (ret == S_INV_DIV) r1 <= $signed(12'(drsp.rem[9:0]));
        end
        S_SQ: begin
          dreq.start <= 1'b1;
          dreq.num <= 64'(acc) * 64'(acc);
          dreq.den <= 64'(m);
          ret <= S_MUL;
          state <= S_WAIT;
        end
        S_MUL: begin
          if (e[bitn]) begin
            dreq.start <= 1'b1;
            dreq.num <= 64'(acc) * 64'(base);
            dreq.den <= 64'(m);
            ret <= S_NEXT;
            state <= S_WAIT;
          end else begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (bitn != 5'd0) begin
            bitn <= bitn - 5'd1;
            state <= S_SQ;
          end else if (!dmode) begin
            value <= acc;
            state <= S_OUT;
          end else begin
            res[pidx] <= acc[9:0];
            if (pidx == 2'd2) begin
              pidx <= 2'd0;
              state <= S_INV_INIT;
            end else begin
              pidx <= pidx + 2'd1;
              m <= (pidx == 2'd0) ? 30'(p2 & 10'((1 << PRIME_BITS) - 1))
                                  : 30'(p3 & 10'((1 << PRIME_BITS) - 1));
              state <= S_RBASE;
            end
          end
        end
        S_INV_INIT: begin
          // x = prod mod p
          dreq.start <= 1'b1;
          dreq.num <= 64'(prod);
          dreq.den <= 64'(pm);
          t0 <= 12'sd0;
          t1 <= 12'sd1;
          r0 <= $signed({2'b00, pm});
          ret <= S_INV_DIV;
          state <= S_WAIT;
        end
        S_INV_DIV: begin
          if (r1 == 12'sd0) begin
            // inverse done: t0 if r0 == 1
            if (r0 != 12'sd1) t0 <= 12'sd0;
            else if (t0 < 0) t0 <= t0 + $signed({2'b00, pm});
            state <= S_TERM;
          end else begin
            dreq.start <= 1'b1;
            dreq.num <= 64'(r0[9:0]);
            dreq.den <= 64'(r1[9:0]);
            ret <= S_INV_FIX;
            state <= S_WAIT;
          end
        end
        S_INV_FIX: begin
          // quotient and remainder hold on the divider outputs
          r0 <= r1;
          r1 <= $signed(12'(drsp.rem[9:0]));
          t0 <= t1;
          t1 <= 12'(t0 - 12'(signed'({1'b0, drsp.quo[10:0]}) * t1));
          state <= S_INV_DIV;
        end
        S_TERM: begin
          dreq.start <= 1'b1;
          dreq.num <= 64'(res[pidx]) * 64'(t0[9:0]);
          dreq.den <= 64'(pm);
          ret <= S_ACC;
          state <= S_WAIT;
        end
        S_ACC: begin
          sum <= sum + 64'(drsp.rem[9:0]) * 64'(prod);
          if (pidx == 2'd2) begin
            state <= S_FINAL;
          end else begin
            pidx <= pidx + 2'd1;
            state <= S_INV_INIT;
          end
        end
        S_FINAL: begin
          dreq.start <= 1'b1;
          dreq.num <= sum;
          dreq.den <= 64'(modn);
          ret <= S_OUT;
          state <= S_WAIT;
        end
        S_OUT: begin
          if (dmode) value <= drsp.rem[29:0];
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_done_idle, done, !busy)
  `ASSERT_IMPL(a_done_busy, done, !$past(done))
  `ASSERT_NEXT(a_start_busy, start && !busy, busy)
endmodule

>>> tb/three_prime_rsa_crt_cipher_tb.sv
`timescale 1ns / 1ps

module three_prime_rsa_crt_cipher_tb;
  import tpr_pkg::*;

  localparam logic [2:0] IDX_SPARE_LO = 3'd6;
  localparam logic [2:0] IDX_SPARE_HI = 3'd7;
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;
  localparam logic [29:0] WORD_MAX = 30'h3FFFFFFF;
  localparam int CYCLE_LIMIT = 40_000_000;
  localparam int SETTLE = 200;

  class cipher_scoreboard;
    logic [29:0] pub_exp, priv_exp, n_mod;
    logic [9:0] p1, p2, p3;
    logic [29:0] pending_values[$];
    int errors;

    function new();
      reset_regs();
      errors = 0;
    endfunction

    function void reset_regs();
      pub_exp = 30'd65537;
      priv_exp = 30'd1;
      p1 = 10'd2;
      p2 = 10'd3;
      p3 = 10'd5;
      n_mod = 30'd30;
    endfunction

    function void set_reg(logic [2:0] idx, logic [29:0] data);
      case (idx)
        REG_PUB: pub_exp = data;
        REG_PRIV: priv_exp = data;
        REG_P1: p1 = data[9:0];
        REG_P2: p2 = data[9:0];
        REG_P3: p3 = data[9:0];
        REG_MOD: n_mod = data;
        default: ;
      endcase
    endfunction

    function longint unsigned mulmod(longint unsigned x, longint unsigned y,
                                     longint unsigned m);
      if (m == 0) return 0;
      return ((x % m) * (y % m)) % m;
    endfunction

    function longint unsigned powmod(longint unsigned b, logic [29:0] e,
                                     longint unsigned m);
      longint unsigned acc;
      if (m == 0) return 0;
      acc = 1 % m;
      for (int i = 29; i >= 0; i--) begin
        acc = mulmod(acc, acc, m);
        if (e[i]) acc = mulmod(acc, b, m);
      end
      return acc;
    endfunction

    // Extended Euclid; 0 when x has no inverse modulo m
    function longint unsigned invmod(longint unsigned x, longint unsigned m);
      longint r0, r1, t0, t1, q, tmp, mm;
      if (m == 0) return 0;
      mm = m;
      r0 = mm;
      r1 = x % m;
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
        q = r0 / r1;
        tmp = r0 - q * r1; r0 = r1; r1 = tmp;
        tmp = t0 - q * t1; t0 = t1; t1 = tmp;
      end
      if (r0 != 1) return 0;
      t0 = t0 % mm;
      if (t0 < 0) t0 += mm;
      return t0;
    endfunction

    function logic [29:0] cipher_value(logic md, logic [29:0] msg);
      longint unsigned p, q, r, qr, pr, pq, ta, tb, tc, total;
      if (md == MODE_ENC) return 30'(powmod(msg, pub_exp, n_mod));
      p = p1; q = p2; r = p3;
      qr = q * r; pr = p * r; pq = p * q;
      ta = mulmod(powmod(msg, priv_exp, p), invmod(qr, p), p);
      tb = mulmod(powmod(msg, priv_exp, q), invmod(pr, q), q);
      tc = mulmod(powmod(msg, priv_exp, r), invmod(pq, r), r);
      total = ta * qr + tb * pr + tc * pq;
      if (n_mod == 0) return 0;
      return 30'(total % n_mod);
    endfunction

    function void note_item(logic md, logic [29:0] msg);
      pending_values.push_back(cipher_value(md, msg));
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_value(logic [29:0] got);
      logic [29:0] want;
      if (pending_values.size() == 0) begin
        report($sformatf("unexpected value %0d", got));
        return;
      end
      want = pending_values.pop_front();
      if (got !== want) report($sformatf("value %0d, want %0d", got, want));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic mode = 1'b0;
  logic [29:0] message = '0;
  logic done;
  logic [29:0] value;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = '0;
  logic [29:0] wr_data = '0;

  cipher_scoreboard sb = new();
  int cycles = 0;
  bit quiet = 1'b0;
  int items_sent = 0;

  three_prime_rsa_crt_cipher dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .message(message), .done(done), .value(value), .wr_en(wr_en),
    .wr_index(wr_index), .wr_data(wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_value(value);
  end

  // Start stays high across back-to-back items; drop it only for a gap.
  task send_item(logic md, logic [29:0] msg);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= md;
    message <= msg;
    do @(posedge clk); while (busy);
    sb.note_item(md, msg);
    items_sent++;
  endtask

  task drain();
    start <= 1'b0;
    while (sb.pending_values.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_reg(logic [2:0] idx, logic [29:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task end_writes();
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bit prime_ok(int v);
    if (v < 2) return 0;
    for (int d = 2; d * d <= v; d++) if (v % d == 0) return 0;
    return 1;
  endfunction

  function automatic int draw_prime();
    int v;
    do v = $urandom_range(2, 1021); while (!prime_ok(v));
    return v;
  endfunction

  // Proper three-prime key with matching exponents
  task load_key();
    int p, q, r;
    longint unsigned phi, e, d;
    p = draw_prime();
    do q = draw_prime(); while (q == p);
    do r = draw_prime(); while (r == p || r == q);
    phi = longint'(p - 1) * (q - 1) * (r - 1);
    do begin
      e = $urandom_range(3, 1 << 20) | 1;
      d = sb.invmod(e, phi);
    end while (d == 0);
    write_reg(REG_P1, 30'(p | ($urandom_range(0, 1) ? ($urandom << 10) : 0)));
    write_reg(REG_P2, 30'(q));
    write_reg(REG_P3, 30'(r));
    write_reg(REG_MOD, 30'(p * q * r));
    write_reg(REG_PUB, 30'(e));
    write_reg(REG_PRIV, 30'(d));
    end_writes();
  endtask

  task load_noise();
    write_reg(REG_PUB, $urandom_range(0, 3) == 0 ? 30'd0 : 30'($urandom));
    write_reg(REG_PRIV, $urandom_range(0, 3) == 0 ? WORD_MAX : 30'($urandom));
    write_reg(REG_P1, 30'($urandom));
    write_reg(REG_P2, 30'($urandom_range(0, 1023)));
    write_reg(REG_P3, $urandom_range(0, 7) == 0 ? 30'd0 : 30'(draw_prime()));
    write_reg(REG_MOD, $urandom_range(0, 7) == 0 ? 30'd0 : 30'($urandom));
    end_writes();
  endtask

  task directed_item(logic md, logic [29:0] msg);
    send_item(md, msg);
    drain();
  endtask

  initial begin
    logic [29:0] plain, ct;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults, messages below and not below modulus
    directed_item(MODE_ENC, 30'd0);
    directed_item(MODE_ENC, WORD_MAX);
    directed_item(MODE_DEC, 30'd29);
    directed_item(MODE_DEC, WORD_MAX);

    // largest distinct primes and extreme exponents
    write_reg(REG_P1, 30'd1021);
    write_reg(REG_P2, 30'd1019);
    write_reg(REG_P3, 30'd1013);
    write_reg(REG_MOD, 30'd1053924187);
    write_reg(REG_PUB, WORD_MAX);
    write_reg(REG_PRIV, WORD_MAX);
    write_reg(IDX_SPARE_LO, 30'd12345);
    write_reg(IDX_SPARE_HI, WORD_MAX);
    end_writes();
    directed_item(MODE_ENC, 30'd1053924186);
    directed_item(MODE_DEC, 30'h2AAAAAAA);
    directed_item(MODE_DEC, 30'h15555555);

    // zero exponents, zero modulus, zero prime, wide prime writes
    write_reg(REG_PUB, 30'd0);
    write_reg(REG_PRIV, 30'd0);
    write_reg(REG_P1, 30'h3FFFFFFF);
    write_reg(REG_P3, 30'd0);
    write_reg(REG_MOD, 30'd0);
    end_writes();
    directed_item(MODE_ENC, 30'd77);
    directed_item(MODE_DEC, 30'd77);
    write_reg(REG_MOD, 30'd1);
    end_writes();
    directed_item(MODE_ENC, WORD_MAX);
    directed_item(MODE_DEC, WORD_MAX);

    // repeated primes have no inverse
    write_reg(REG_P1, 30'd7);
    write_reg(REG_P2, 30'd7);
    write_reg(REG_P3, 30'd11);
    write_reg(REG_MOD, 30'd539);
    write_reg(REG_PUB, 30'd3);
    write_reg(REG_PRIV, 30'd5);
    end_writes();
    directed_item(MODE_ENC, 30'd100);
    directed_item(MODE_DEC, 30'd538);

    while (items_sent < 300) begin
      if ($urandom_range(0, 4) == 0) load_noise();
      else load_key();
      repeat (15) begin
        if (items_sent > 260) quiet = 1'b1;
        if ($urandom_range(0, 4) == 0) begin
          send_item(1'($urandom_range(0, 1)), 30'($urandom));
        end else begin
          // round trip: encrypt a word, then decrypt its ciphertext
          plain = (sb.n_mod == 0) ? 30'd0 : 30'($urandom % sb.n_mod);
          ct = sb.cipher_value(MODE_ENC, plain);
          send_item(MODE_ENC, plain);
          send_item(MODE_DEC, ct);
        end
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending_values.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
